[sv/mrle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrle_pkg
// Shared types and constants of the monochrome run-length row decoder.
// ----------------------------------------------------------------------------
package mrle_pkg;

	localparam int WIDTH_BITS_DEF = 16;
	localparam int BYTE_W         = 8;
	localparam int BITS_W         = 11;
	localparam int FB_W           = 3;
	localparam int MIN_WIDTH      = 64;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;
	localparam int TDATA_W        = 24;

	localparam logic [CFG_IDX_W-1:0] REG_CODED_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 1'd1;

	typedef enum logic [1:0] {
		PH_TYPE  = 2'd0,
		PH_COUNT = 2'd1,
		PH_VALUE = 2'd2,
		PH_LIT   = 2'd3
	} phase_t;

	// request to emit bits of one byte value
	typedef struct packed {
		logic              raw;
		logic [BYTE_W-1:0] value;
		logic [BITS_W-1:0] bits;
	} seg_req_t;

endpackage

[sv/mrle_seg_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrle_seg_unit
// Cuts the bits of one byte value into row segments, one segment per cycle
// while the output is not stalled, with a single shared subtract and compare
// unit and a registered output.
module mrle_seg_unit
	import mrle_pkg::*;
#(
	parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  restart,
	input  logic                  req_valid,
	input  seg_req_t              req,
	input  logic [WIDTH_BITS-1:0] width,
	output logic                  busy,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,
	output logic                  m_tlast
);

	localparam int CMP_W = (WIDTH_BITS > BITS_W) ? WIDTH_BITS : BITS_W;

	logic                  busy_q;
	logic                  raw_q;
	logic [BYTE_W-1:0]     value_q;
	logic [BITS_W-1:0]     bits_q;
	logic [FB_W-1:0]       fb_q;
	logic [WIDTH_BITS-1:0] column_q;

	logic                  m_tvalid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic [FB_W-1:0]       out_fb_q;
	logic [BITS_W-1:0]     out_cnt_q;
	logic                  out_rend_q;
	logic                  out_last_q;

	logic [WIDTH_BITS-1:0] space;
	logic [CMP_W-1:0]      space_c;
	logic [CMP_W-1:0]      left_c;
	logic [CMP_W-1:0]      step_c;
	logic                  fits;
	logic [BITS_W-1:0]     left_after;
	logic                  fire;

	// shared unit: room left in the row against bits still to place
	always_comb begin
		space      = width - column_q;
		space_c    = CMP_W'(space);
		left_c     = CMP_W'(bits_q);
		fits       = left_c < space_c;
		// coded mode drops the rest of a partly used byte at row end
		step_c     = raw_q ? space_c : ((space_c + CMP_W'(7)) & ~CMP_W'(7));
		left_after = bits_q - BITS_W'(step_c);
		fire       = busy_q && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			column_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else if (restart) begin
			busy_q     <= 1'b0;
			column_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (req_valid) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				if (fits) begin
					busy_q   <= 1'b0;
					column_q <= column_q + WIDTH_BITS'(bits_q);
				end else begin
					busy_q   <= (left_after != '0);
					column_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			raw_q   <= req.raw;
			value_q <= req.value;
			bits_q  <= req.bits;
			fb_q    <= '0;
		end else if (fire && !fits) begin
			bits_q <= left_after;
			fb_q   <= raw_q ? fb_q + space[FB_W-1:0] : '0;
		end
		if (fire) begin
			out_byte_q <= value_q;
			out_fb_q   <= fb_q;
			out_cnt_q  <= fits ? bits_q : BITS_W'(space_c);
			out_rend_q <= !fits;
			out_last_q <= fits || (left_after == '0);
		end
	end

	assign busy     = busy_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_rend_q, out_cnt_q, out_fb_q, out_byte_q};
	assign m_tlast  = out_last_q;

endmodule

[sv/monochrome_rle_row_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monochrome_rle_row_decoder
// Record parser and configuration of the 1-bit bitmap row decoder.
// ----------------------------------------------------------------------------
// Usage:
// - s_tdata carries one byte of the pixel stream per transaction.
// - m_tdata carries one pixel segment per transaction; m_tlast marks the
//   final segment caused by an input byte. Header bytes give no segment.
// - cfg_we/cfg_index/cfg_data write coded_mode (0) or row_width (1); any
//   write restarts decoding at the start of a row and of a record.
// - Flow: a byte is taken into the request registers of the segment unit,
//   which then places one segment per cycle in the output register while
//   the receiver does not stall. s_tready stays low until the last segment
//   of the byte is placed; header bytes give no segment and do not lower it.
//   A long run crossing many rows gives one segment per row.
// - The rate is set by the single subtract/compare unit, one segment a pass.
// - When the receiver stalls, the segment is held in the output register
//   and the unit waits; the next byte is taken once the last segment of the
//   current one has reached the output register.
// - Reset sets coded mode, a width of 640 and an empty row.
// ----------------------------------------------------------------------------
module monochrome_rle_row_decoder
	import mrle_pkg::*;
#(
	parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // in_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // pixel_byte, first_bit, bit_count, row_end, pad
	output logic                  m_tlast
);

	logic                  coded_mode_q;
	logic [CFG_DATA_W-1:0] row_width_q;
	phase_t                phase_q;
	phase_t                phase_d;
	logic [BYTE_W-1:0]     lit_left_q;
	logic [BYTE_W-1:0]     run_len_q;

	logic                  busy;
	logic                  in_acc;
	logic                  restart;
	logic                  req_valid;
	seg_req_t              req;
	logic [WIDTH_BITS-1:0] width_masked;
	logic [WIDTH_BITS-1:0] width_eff;

	assign s_tready = !busy;
	assign in_acc   = s_tvalid && s_tready;
	assign restart  = cfg_we && (cfg_index == REG_CODED_MODE || cfg_index == REG_ROW_WIDTH);

	// narrow widths are treated as the minimum
	always_comb begin
		width_masked = row_width_q[WIDTH_BITS-1:0];
		width_eff    = (width_masked < WIDTH_BITS'(MIN_WIDTH)) ?
			WIDTH_BITS'(MIN_WIDTH) : width_masked;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coded_mode_q <= 1'b1;
			row_width_q  <= CFG_DATA_W'(640);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CODED_MODE: coded_mode_q <= cfg_data[0];
				REG_ROW_WIDTH:  row_width_q  <= cfg_data;
				default:        ;
			endcase
		end
	end

	// next phase of the record parser
	always_comb begin
		phase_d = phase_q;
		if (in_acc && coded_mode_q) begin
			case (phase_q)
				PH_TYPE:  phase_d = (s_tdata == '0) ? PH_COUNT : PH_LIT;
				PH_COUNT: phase_d = PH_VALUE;
				PH_VALUE: phase_d = PH_TYPE;
				PH_LIT:   phase_d = (lit_left_q == BYTE_W'(1)) ? PH_TYPE : PH_LIT;
				default:  phase_d = PH_TYPE;
			endcase
		end
	end

	// segment requests from the parser
	always_comb begin
		req_valid = 1'b0;
		req.raw   = !coded_mode_q;
		req.value = s_tdata;
		req.bits  = BITS_W'(BYTE_W);
		if (in_acc) begin
			if (!coded_mode_q) begin
				req_valid = 1'b1;
			end else begin
				case (phase_q)
					PH_VALUE: begin
						req_valid = (run_len_q != '0);
						req.bits  = {run_len_q, 3'b000};
					end
					PH_LIT:  req_valid = 1'b1;
					default: req_valid = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			lit_left_q <= '0;
			run_len_q  <= '0;
		end else if (restart) begin
			phase_q    <= PH_TYPE;
			lit_left_q <= '0;
			run_len_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (in_acc && coded_mode_q) begin
				case (phase_q)
					PH_TYPE:  lit_left_q <= (s_tdata == '0) ? lit_left_q : s_tdata;
					PH_COUNT: run_len_q  <= s_tdata;
					PH_VALUE: run_len_q  <= '0;
					PH_LIT:   lit_left_q <= lit_left_q - BYTE_W'(1);
					default:  ;
				endcase
			end
		end
	end

	mrle_seg_unit #(
		.WIDTH_BITS(WIDTH_BITS)
	) u_seg (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.req_valid(req_valid),
		.req      (req),
		.width    (width_eff),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
